// File: rtl/pbdf_pkg.sv
// ----------------------------------------------------------------------------
// pbdf_pkg
// Shared types, constants and the hex digit decoder for the PCI BDF parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pbdf_pkg;

	localparam logic [7:0] SEP_COLON = 8'h3A;
	localparam logic [7:0] SEP_DOT   = 8'h2E;

	// Character positions; the position counter stops at POS_SAT.
	localparam logic [3:0] LONG_LEN  = 4'd12;
	localparam logic [3:0] SHORT_LEN = 4'd7;
	localparam logic [3:0] POS_SAT   = 4'd13;

	localparam logic [3:0] L_COLON0  = 4'd4;
	localparam logic [3:0] L_COLON1  = 4'd7;
	localparam logic [3:0] L_DOT     = 4'd10;
	localparam logic [3:0] S_COLON   = 4'd2;
	localparam logic [3:0] S_DOT     = 4'd5;

	typedef struct packed {
		logic [7:0] name_char;
		logic       last_char;
	} pbdf_in_t;

	typedef struct packed {
		logic [31:0] pci_address;
		logic        parse_ok;
	} pbdf_out_t;

	typedef struct packed {
		logic [4:0] nib;  // [4] = is a hex digit, [3:0] = value
	} pbdf_hex_t;

	function automatic pbdf_hex_t hex_decode(input logic [7:0] c);
		pbdf_hex_t r;
		r.nib = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.nib = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.nib = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.nib = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/pbdf_stream_if.sv
// ----------------------------------------------------------------------------
// pbdf_stream_if
// Valid/ready channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbdf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/pbdf_parse.sv
// ----------------------------------------------------------------------------
// pbdf_parse
// Position counter, form checks and field accumulators for both name forms.
// ----------------------------------------------------------------------------
`default_nettype none

module pbdf_parse
	import pbdf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,     // consume the character below
	input  wire pbdf_in_t  chr,
	output pbdf_out_t      res       // valid when step && chr.last_char
);

	logic [3:0]  pos_q;
	logic        long_ok_q, short_ok_q;
	logic [15:0] dom_q;
	logic [7:0]  lbus_q, lslot_q, sbus_q, sslot_q;
	logic [3:0]  lfunc_q, sfunc_q;

	logic [3:0]  pos_d;
	logic        long_ok_d, short_ok_d;
	logic [15:0] dom_d;
	logic [7:0]  lbus_d, lslot_d, sbus_d, sslot_d;
	logic [3:0]  lfunc_d, sfunc_d;
	pbdf_hex_t   hx;
	logic        is_hex;
	logic [3:0]  nib;
	logic [7:0]  c;

	always_comb begin
		c      = chr.name_char;
		hx     = hex_decode(c);
		is_hex = hx.nib[4];
		nib    = hx.nib[3:0];

		pos_d      = (pos_q < POS_SAT) ? pos_q + 4'd1 : pos_q;
		long_ok_d  = long_ok_q;
		short_ok_d = short_ok_q;
		dom_d      = dom_q;
		lbus_d     = lbus_q;
		lslot_d    = lslot_q;
		lfunc_d    = lfunc_q;
		sbus_d     = sbus_q;
		sslot_d    = sslot_q;
		sfunc_d    = sfunc_q;

		// long form DDDD:BB:SS.F
		if (pos_q < LONG_LEN) begin
			if (pos_q == L_COLON0 || pos_q == L_COLON1) begin
				if (c != SEP_COLON) long_ok_d = 1'b0;
			end else if (pos_q == L_DOT) begin
				if (c != SEP_DOT) long_ok_d = 1'b0;
			end else if (!is_hex) begin
				long_ok_d = 1'b0;
			end else if (pos_q < L_COLON0) begin
				dom_d = {dom_q[11:0], nib};
			end else if (pos_q < L_COLON1) begin
				lbus_d = {lbus_q[3:0], nib};
			end else if (pos_q < L_DOT) begin
				lslot_d = {lslot_q[3:0], nib};
			end else begin
				lfunc_d = nib;
			end
		end

		// short form BB:SS.F
		if (pos_q < SHORT_LEN) begin
			if (pos_q == S_COLON) begin
				if (c != SEP_COLON) short_ok_d = 1'b0;
			end else if (pos_q == S_DOT) begin
				if (c != SEP_DOT) short_ok_d = 1'b0;
			end else if (!is_hex) begin
				short_ok_d = 1'b0;
			end else if (pos_q < S_COLON) begin
				sbus_d = {sbus_q[3:0], nib};
			end else if (pos_q < S_DOT) begin
				sslot_d = {sslot_q[3:0], nib};
			end else begin
				sfunc_d = nib;
			end
		end

		// fields are ORed as written: slot may overlap bus, func may overlap slot
		res = '0;
		if (pos_d == LONG_LEN && long_ok_d) begin
			res.parse_ok    = 1'b1;
			res.pci_address = {dom_d, 16'd0} | {16'd0, lbus_d, 8'd0}
			                | {21'd0, lslot_d, 3'd0} | {28'd0, lfunc_d};
		end else if (pos_d == SHORT_LEN && short_ok_d) begin
			res.parse_ok    = 1'b1;
			res.pci_address = {16'd0, sbus_d, 8'd0}
			                | {21'd0, sslot_d, 3'd0} | {28'd0, sfunc_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			long_ok_q  <= 1'b1;
			short_ok_q <= 1'b1;
			dom_q      <= '0;
			lbus_q     <= '0;
			lslot_q    <= '0;
			lfunc_q    <= '0;
			sbus_q     <= '0;
			sslot_q    <= '0;
			sfunc_q    <= '0;
		end else if (step) begin
			if (chr.last_char) begin
				pos_q      <= '0;
				long_ok_q  <= 1'b1;
				short_ok_q <= 1'b1;
				dom_q      <= '0;
				lbus_q     <= '0;
				lslot_q    <= '0;
				lfunc_q    <= '0;
				sbus_q     <= '0;
				sslot_q    <= '0;
				sfunc_q    <= '0;
			end else begin
				pos_q      <= pos_d;
				long_ok_q  <= long_ok_d;
				short_ok_q <= short_ok_d;
				dom_q      <= dom_d;
				lbus_q     <= lbus_d;
				lslot_q    <= lslot_d;
				lfunc_q    <= lfunc_d;
				sbus_q     <= sbus_d;
				sslot_q    <= sslot_d;
				sfunc_q    <= sfunc_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/pbdf_out_reg.sv
// ----------------------------------------------------------------------------
// pbdf_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pbdf_out_reg
	import pbdf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire pbdf_out_t  res,
	output logic            free,    // register can take a result this cycle
	pbdf_stream_if.source   result
);

	logic      vld_q;
	pbdf_out_t data_q;

	assign free         = !vld_q || result.ready;
	assign result.valid = vld_q;
	assign result.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/pci_bdf_string_parser_core.sv
// ----------------------------------------------------------------------------
// pci_bdf_string_parser_core
// Parses a PCI device name (DDDD:BB:SS.F or BB:SS.F) streamed one character
// per transaction into a packed address and an ok flag.
// ----------------------------------------------------------------------------
// The last character passes the input register; its result is then held in the output register.
// Throughput: one character per cycle; one result per name, on its last char.
// The input register stalls only while a result sits unaccepted in the
// output register and a further last character waits to be evaluated.
// Reset (arst_n low): both registers empty, parser back at position zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_bdf_string_parser_core
	import pbdf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	pbdf_stream_if.sink   chars,
	pbdf_stream_if.source result
);

	// input register
	logic     vld_s1;
	pbdf_in_t chr_s1;

	// control between stages
	logic      out_free;
	logic      advance;
	pbdf_out_t res;

	// A non-final character never needs the output register, so it moves on
	// regardless of downstream backpressure.
	assign advance     = vld_s1 && (!chr_s1.last_char || out_free);
	assign chars.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chars.ready) begin
			vld_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			chr_s1 <= chars.data;
		end
	end

	// position, checks and accumulators; result formed from the updated state
	pbdf_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.chr    (chr_s1),
		.res    (res)
	);

	// result register, loaded when the final character is consumed
	pbdf_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && chr_s1.last_char),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

endmodule

`default_nettype wire

// File: test/pci_bdf_string_parser_core_test.sv
// ----------------------------------------------------------------------------
// pci_bdf_string_parser_core_test
// Streams PCI device names into the parser one character per transaction and
// checks every packed address and ok flag against a cycle-free shadow parser.
// Names are well formed long and short forms, corrupted, cut short, overlong
// and plain noise, with random idling on both channels.
// ----------------------------------------------------------------------------
module pci_bdf_string_parser_core_test
	import pbdf_pkg::*;
;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 8;
	localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction at all
	localparam int SETTLE_CYCLES = 10;    // wait after the drain before the final check

	logic clk;
	logic arst_n;

	pbdf_stream_if #(.payload_t(pbdf_in_t))  chars_if ();
	pbdf_stream_if #(.payload_t(pbdf_out_t)) result_if ();

	pci_bdf_string_parser_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	// Shadow parser state
	logic [3:0]  cur_pos;
	logic        long_ok;
	logic        short_ok;
	logic [15:0] dom_acc;
	logic [7:0]  long_bus;
	logic [7:0]  long_slot;
	logic [3:0]  long_func;
	logic [7:0]  short_bus;
	logic [7:0]  short_slot;
	logic [3:0]  short_func;

	pbdf_out_t  pending_addresses[$];
	logic [7:0] name_buf[$];

	bit idle_on = 1'b1;
	int hold_left = 0;
	int error_count = 0;
	int chars_sent = 0;
	int names_sent = 0;
	int results_checked = 0;
	int quiet_cycles = 0;

	always #(HALF_PERIOD) clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// ------------------------------------------------------------------------
	// Shadow parser
	// ------------------------------------------------------------------------
	function automatic bit nibble_of(input logic [7:0] c, output logic [3:0] v);
		v = 4'h0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end else if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 10);
			return 1'b1;
		end else if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic clear_parser();
		cur_pos    = 4'd0;
		long_ok    = 1'b1;
		short_ok   = 1'b1;
		dom_acc    = 16'h0000;
		long_bus   = 8'h00;
		long_slot  = 8'h00;
		long_func  = 4'h0;
		short_bus  = 8'h00;
		short_slot = 8'h00;
		short_func = 4'h0;
	endtask

	// Advance the shadow parser by one accepted character; on the last one
	// queue the address it should produce.
	task automatic parse_char(input pbdf_in_t item);
		logic [7:0]  c;
		logic [3:0]  v;
		logic [31:0] addr;
		bit          is_hex;
		pbdf_out_t   res;
		c = item.name_char;
		is_hex = nibble_of(c, v);
		if (cur_pos < LONG_LEN) begin
			if (cur_pos == L_COLON0 || cur_pos == L_COLON1) begin
				if (c != SEP_COLON) long_ok = 1'b0;
			end else if (cur_pos == L_DOT) begin
				if (c != SEP_DOT) long_ok = 1'b0;
			end else if (!is_hex) begin
				long_ok = 1'b0;
			end else if (cur_pos < L_COLON0) begin
				dom_acc = {dom_acc[11:0], v};
			end else if (cur_pos < L_COLON1) begin
				long_bus = {long_bus[3:0], v};
			end else if (cur_pos < L_DOT) begin
				long_slot = {long_slot[3:0], v};
			end else begin
				long_func = v;
			end
		end
		if (cur_pos < SHORT_LEN) begin
			if (cur_pos == S_COLON) begin
				if (c != SEP_COLON) short_ok = 1'b0;
			end else if (cur_pos == S_DOT) begin
				if (c != SEP_DOT) short_ok = 1'b0;
			end else if (!is_hex) begin
				short_ok = 1'b0;
			end else if (cur_pos < S_COLON) begin
				short_bus = {short_bus[3:0], v};
			end else if (cur_pos < S_DOT) begin
				short_slot = {short_slot[3:0], v};
			end else begin
				short_func = v;
			end
		end
		if (cur_pos < POS_SAT) cur_pos = cur_pos + 4'd1;
		if (!item.last_char) return;

		// Fields are ORed as written: slot may overlap bus, func may overlap slot.
		addr = 32'h0;
		res.parse_ok = 1'b0;
		if (cur_pos == LONG_LEN && long_ok) begin
			addr = {dom_acc, 16'h0000} | {16'h0000, long_bus, 8'h00} |
				({24'h0, long_slot} << 3) | {28'h0, long_func};
			res.parse_ok = 1'b1;
		end else if (cur_pos == SHORT_LEN && short_ok) begin
			addr = {16'h0000, short_bus, 8'h00} |
				({24'h0, short_slot} << 3) | {28'h0, short_func};
			res.parse_ok = 1'b1;
		end
		res.pci_address = addr;
		pending_addresses.push_back(res);
		clear_parser();
	endtask

	// ------------------------------------------------------------------------
	// Character sender
	// ------------------------------------------------------------------------
	task automatic send_char(input logic [7:0] c, input logic last);
		pbdf_in_t item;
		int gap;
		item.name_char = c;
		item.last_char = last;
		@(negedge clk);
		chars_if.valid <= 1'b1;
		chars_if.data  <= item;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		parse_char(item);
		chars_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			chars_if.valid <= 1'b0;
			chars_if.data  <= pbdf_in_t'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Valid may still be high after a zero gap; drop it before going quiet.
	task automatic release_chars();
		@(negedge clk);
		chars_if.valid <= 1'b0;
	endtask

	task automatic send_name();
		foreach (name_buf[i]) begin
			send_char(name_buf[i], i == name_buf.size() - 1);
		end
		names_sent++;
	endtask

	task automatic wait_results_drained();
		release_chars();
		while (pending_addresses.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Name builders
	// ------------------------------------------------------------------------
	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return 8'("0" + v);
		if ($urandom_range(0, 1)) return 8'("a" + v - 10);
		return 8'("A" + v - 10);
	endfunction

	task automatic load_text(input string s);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
	endtask

	task automatic make_valid_name(input bit long_form);
		name_buf.delete();
		if (long_form) begin
			repeat (4) name_buf.push_back(rand_hex_char());
			name_buf.push_back(SEP_COLON);
		end
		repeat (2) name_buf.push_back(rand_hex_char());
		name_buf.push_back(SEP_COLON);
		repeat (2) name_buf.push_back(rand_hex_char());
		name_buf.push_back(SEP_DOT);
		name_buf.push_back(rand_hex_char());
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		load_text("FFFF:FF:FF.F");
		send_name();
		load_text("00:00.0");
		send_name();
		// code zero then 0xFF: two characters, neither hex nor separator
		name_buf.delete();
		name_buf.push_back(8'h00);
		name_buf.push_back(8'hFF);
		send_name();
	endtask

	task automatic test_well_formed_names();
		repeat (8) begin
			make_valid_name($urandom_range(0, 1));
			send_name();
		end
	endtask

	task automatic test_malformed_names();
		int kind;
		int idx;
		int extra;
		repeat (24) begin
			kind = $urandom_range(0, 3);
			case (kind)
				0: begin
					make_valid_name($urandom_range(0, 1));
					idx = $urandom_range(0, name_buf.size() - 1);
					name_buf[idx] = 8'($urandom_range(0, 255));
				end
				1: begin
					make_valid_name($urandom_range(0, 1));
					extra = $urandom_range(1, name_buf.size() - 1);
					repeat (extra) void'(name_buf.pop_back());
				end
				2: begin
					// overlong names run past their form's length, at times past the saturation point
					make_valid_name($urandom_range(0, 1));
					extra = $urandom_range(1, 8);
					repeat (extra) name_buf.push_back($urandom_range(0, 1) ?
						rand_hex_char() : 8'($urandom_range(0, 255)));
				end
				default: begin
					name_buf.delete();
					extra = $urandom_range(1, 16);
					repeat (extra) name_buf.push_back(8'($urandom_range(0, 255)));
				end
			endcase
			send_name();
		end
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (10) begin
			if ($urandom_range(0, 3) == 0) begin
				make_valid_name(1'b1);
				name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom);
			end else begin
				make_valid_name($urandom_range(0, 1));
			end
			send_name();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_paused_sender();
		repeat (4) begin
			make_valid_name($urandom_range(0, 1));
			send_name();
			wait_results_drained();
		end
	endtask

	// ------------------------------------------------------------------------
	// Result receiver: random stalls, with stretches of none while idle_on is low
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_if.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			result_if.ready <= 1'b1;
			hold_left = pick_gap();
		end
	end

	always @(posedge clk) begin : check_results
		pbdf_out_t got;
		pbdf_out_t want;
		if (result_if.valid && result_if.ready) begin
			got = result_if.data;
			if (pending_addresses.size() == 0) begin
				report_mismatch($sformatf("unexpected result addr=%08h ok=%0b",
					got.pci_address, got.parse_ok));
			end else begin
				want = pending_addresses.pop_front();
				if (got.pci_address !== want.pci_address) begin
					report_mismatch($sformatf("pci_address %08h, expected %08h",
						got.pci_address, want.pci_address));
				end
				if (got.parse_ok !== want.parse_ok) begin
					report_mismatch($sformatf("parse_ok %0b, expected %0b",
						got.parse_ok, want.parse_ok));
				end
				results_checked++;
			end
		end
	end

	// Watchdog: any transaction on either channel counts as progress
	always @(posedge clk) begin
		if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("pci_bdf_string_parser_core test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.data = '0;
		result_if.ready = 1'b0;
		clear_parser();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_well_formed_names();
		test_paused_sender();
		test_malformed_names();
		test_back_to_back();
		test_well_formed_names();

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_addresses.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_addresses.size()));
		end

		$display("%0d characters in %0d names sent, %0d results checked",
			chars_sent, names_sent, results_checked);
		$display("long, short, corrupted, cut, overlong and noise names under random stalls");
		if (error_count == 0) begin
			$display("pci_bdf_string_parser_core test passed");
		end else begin
			$display("pci_bdf_string_parser_core test failed");
		end
		$finish;
	end

endmodule
